// ===== sv/pcdq_pkg.sv =====
// ----------------------------------------------------------------------------
// pcdq_pkg: shared types and constants of the PI controller with quantizer
// Fixed-point formats, shaper coefficients, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pcdq_pkg;

  // State word: integrator Q16.(W-16), shaper states Q8.(W-8)
  localparam int STATE_WIDTH = 32;
  localparam int INT_FRAC    = STATE_WIDTH - 16;
  localparam int SH_FRAC     = STATE_WIDTH - 8;
  localparam int COEF_FRAC   = 24;

  // Digit-serial multiplier: parallel magnitude times serial digits
  localparam int MC_W   = STATE_WIDTH;
  localparam int SER_W  = 32;
  localparam int DIG_W  = 8;
  localparam int NDIG   = SER_W / DIG_W;
  localparam int CNT_W  = $clog2(NDIG);
  localparam int PROD_W = MC_W + SER_W;

  // Accumulator and rounded product widths
  localparam int ACC_W  = STATE_WIDTH + 16;
  localparam int RMAG_W = ACC_W - 1;

  // Rescale shifts of the products and of the Q4.12 values
  localparam int SP_SH    = 28 - INT_FRAC;
  localparam int SP_RSH   = (SP_SH > 0) ? SP_SH : 0;
  localparam int SP_LSH   = (SP_SH < 0) ? -SP_SH : 0;
  localparam int PG_RSH   = 16;
  localparam int IG_RSH   = INT_FRAC + 4;
  localparam int COEF_RSH = COEF_FRAC;
  localparam int US_LSH   = SH_FRAC - 12;

  // Shaper coefficients, 24 fraction bits
  localparam logic [SER_W-1:0] COEF_FB_A = 32'd1388019345;
  localparam logic [SER_W-1:0] COEF_FB_B = 32'd52823232;
  localparam logic [SER_W-1:0] COEF_AA   = 32'd15969343;
  localparam logic [SER_W-1:0] COEF_AB   = 32'd607738;
  localparam logic [SER_W-1:0] COEF_AD   = 32'd193024;
  localparam logic [SER_W-1:0] COEF_BA   = 32'd693580;
  localparam logic [SER_W-1:0] COEF_BB   = 32'd9786452;
  localparam logic [SER_W-1:0] COEF_BD   = 32'd6337536;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_SAMPLE_PERIOD,
    REG_OUTPUT_LEVEL
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [15:0] sample_period;
    logic [14:0] output_level;
  } cfg_t;

  localparam logic [23:0] PROP_GAIN_RST     = 24'd131072;
  localparam logic [23:0] INTEG_GAIN_RST    = 24'd58982;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd3277;
  localparam logic [14:0] OUTPUT_LEVEL_RST  = 15'd10240;

endpackage

`default_nettype wire

// ===== sv/pcdq_if.sv =====
// ----------------------------------------------------------------------------
// pcdq_if: valid/ready channels of the PI controller with quantizer
// Error sample channel and drive result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcdq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] error_in;

  modport source (output valid, output error_in, input ready);
  modport sink   (input valid, input error_in, output ready);
endinterface

interface pcdq_out_if;
  logic               valid;
  logic               ready;
  logic               drive_positive;
  logic signed [15:0] drive_value;
  logic signed [15:0] command_value;

  modport source (output valid, output drive_positive, output drive_value,
                  output command_value, input ready);
  modport sink   (input valid, input drive_positive, input drive_value,
                  input command_value, output ready);
endinterface

`default_nettype wire

// ===== sv/pcdq_cfg.sv =====
// ----------------------------------------------------------------------------
// pcdq_cfg: configuration registers
// Gains, sample period and output level, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdq_cfg import pcdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_PROP_GAIN:     cfg_nxt.prop_gain     = cfg_wdata[23:0];
        REG_INTEG_GAIN:    cfg_nxt.integ_gain    = cfg_wdata[23:0];
        REG_SAMPLE_PERIOD: cfg_nxt.sample_period = cfg_wdata[15:0];
        REG_OUTPUT_LEVEL:  cfg_nxt.output_level  = cfg_wdata[14:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= PROP_GAIN_RST;
      cfg_r.integ_gain    <= INTEG_GAIN_RST;
      cfg_r.sample_period <= SAMPLE_PERIOD_RST;
      cfg_r.output_level  <= OUTPUT_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/pcdq_mul.sv =====
// ----------------------------------------------------------------------------
// pcdq_mul: digit-serial unsigned multiplier
// Parallel magnitude times a serial operand taken one digit per cycle, LSB
// digit first; low product digits shift out into a register of their own.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdq_mul import pcdq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MC_W-1:0]   mcand,
  input  logic [SER_W-1:0]  mplier,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [MC_W-1:0]        mc_r, mc_nxt;
  logic [SER_W-1:0]       ser_r, ser_nxt;
  logic [MC_W-1:0]        hi_r, hi_nxt;
  logic [SER_W-1:0]       lo_r, lo_nxt;
  logic [MC_W+DIG_W-1:0]  part;
  logic [MC_W+DIG_W-1:0]  psum;
  logic                   last;

  assign last = (cnt_r == CNT_W'(NDIG - 1));

  // One digit step: add digit partial product, shift one digit out
  always_comb begin
    part     = (MC_W+DIG_W)'(mc_r) * (MC_W+DIG_W)'(ser_r[DIG_W-1:0]);
    psum     = {{DIG_W{1'b0}}, hi_r} + part;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mc_nxt   = mc_r;
    ser_nxt  = ser_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (busy_r) begin
      hi_nxt  = psum[MC_W+DIG_W-1:DIG_W];
      lo_nxt  = {psum[DIG_W-1:0], lo_r[SER_W-1:DIG_W]};
      ser_nxt = ser_r >> DIG_W;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mc_nxt   = mcand;
      ser_nxt  = mplier;
      hi_nxt   = '0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operands and partial product
  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    ser_r <= ser_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

`default_nettype wire

// ===== sv/pi_control_dynamic_quantizer.sv =====
// ----------------------------------------------------------------------------
// pi_control_dynamic_quantizer: PI controller with noise-shaping quantizer
// A sequencer runs the PI update and the second-order shaper through one
// shared digit-serial multiplier, then hands the binary drive to the output.
// ----------------------------------------------------------------------------
//   channel  direction  payload                                       handshake
//   in_ch    sink       error_in                                      valid/ready
//   out_ch   source     drive_positive, drive_value, command_value    valid/ready
//   cfg_*    sink       cfg_idx, cfg_wdata                            cfg_we
//
// From its transfer in to the output register, an item passes eleven products
// through the multiplier, each with start, wait on NDIG digit steps, round and
// accumulate, and then five state update steps.
// Ready for the next error sample rises the cycle after the result is loaded.
// Synchronous active-low reset clears integrator, shaper states and control.
// A full, stalled output register holds the sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_control_dynamic_quantizer import pcdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pcdq_in_if.sink               in_ch,
  pcdq_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_MSTART, S_MWAIT, S_RND, S_ACC,
    S_INTEG, S_UCMD, S_SIGN, S_STA, S_STB
  } state_t;

  typedef enum logic [3:0] {
    OP_SP, OP_PG, OP_IG, OP_FBA, OP_FBB,
    OP_AA, OP_AB, OP_AD, OP_BA, OP_BB, OP_BD
  } op_t;

  typedef enum logic [1:0] {RND_SP, RND_PG, RND_IG, RND_COEF} rnd_t;

  localparam logic signed [ACC_W-1:0] SW_HI =
    {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SW_LO = ~SW_HI;
  localparam logic signed [ACC_W-1:0] Q_HI  = {{(ACC_W-15){1'b0}}, {15{1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_LO  = ~Q_HI;

  localparam logic [PROD_W:0] ONE_P     = {{PROD_W{1'b0}}, 1'b1};
  localparam logic [PROD_W:0] HALF_SP   = (ONE_P << SP_RSH) >> 1;
  localparam logic [PROD_W:0] HALF_PG   = (ONE_P << PG_RSH) >> 1;
  localparam logic [PROD_W:0] HALF_IG   = (ONE_P << IG_RSH) >> 1;
  localparam logic [PROD_W:0] HALF_COEF = (ONE_P << COEF_RSH) >> 1;

  function automatic logic signed [STATE_WIDTH-1:0] sat_sw(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [STATE_WIDTH-1:0] r;
    if (x > SW_HI) begin
      r = SW_HI[STATE_WIDTH-1:0];
    end else if (x < SW_LO) begin
      r = SW_LO[STATE_WIDTH-1:0];
    end else begin
      r = x[STATE_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_q(input logic signed [ACC_W-1:0] x);
    logic signed [15:0] r;
    if (x > Q_HI) begin
      r = Q_HI[15:0];
    end else if (x < Q_LO) begin
      r = Q_LO[15:0];
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  cfg_t cfg;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic signed [STATE_WIDTH-1:0] integ_r, integ_nxt;
  logic signed [STATE_WIDTH-1:0] sa_r, sa_nxt;
  logic signed [STATE_WIDTH-1:0] sb_r, sb_nxt;
  logic signed [STATE_WIDTH-1:0] na_r, na_nxt;
  logic signed [STATE_WIDTH-1:0] d_r, d_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic [RMAG_W-1:0]             rmag_r, rmag_nxt;
  logic signed [15:0]            e_r, e_nxt;
  logic signed [15:0]            u_r, u_nxt;
  logic signed [15:0]            v_r, v_nxt;
  logic                          pos_r, pos_nxt;
  logic                          drv_pos_r, drv_pos_nxt;
  logic signed [15:0]            drv_val_r, drv_val_nxt;
  logic signed [15:0]            cmd_r, cmd_nxt;

  // Operand decode and multiplier hookup
  logic signed [STATE_WIDTH-1:0] mc_s;
  logic [MC_W-1:0]               mc_mag;
  logic [SER_W-1:0]              mp;
  logic                          sub;
  rnd_t                          rsel;
  logic                          mul_start;
  logic                          mul_done;
  logic [PROD_W-1:0]             mul_prod;

  // Rounding and accumulate
  logic [PROD_W:0]         r_pre, r_half, r_sum, r_shf;
  logic                    flip;
  logic signed [ACC_W-1:0] add_term;

  // Step helpers
  logic signed [15:0]            u_sat;
  logic signed [15:0]            v_pos;
  logic signed [15:0]            v_sel;
  logic signed [16:0]            v_m_u;
  logic                          out_free;

  pcdq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Select multiplicand, serial operand, rounding and add/subtract per op
  always_comb begin
    mc_s = STATE_WIDTH'(e_r);
    mp   = COEF_AA;
    sub  = 1'b0;
    rsel = RND_COEF;
    case (op_r)
      OP_SP: begin
        mp   = SER_W'(cfg.sample_period);
        rsel = RND_SP;
      end
      OP_PG: begin
        mp   = SER_W'(cfg.prop_gain);
        rsel = RND_PG;
      end
      OP_IG: begin
        mc_s = integ_r;
        mp   = SER_W'(cfg.integ_gain);
        rsel = RND_IG;
      end
      OP_FBA: begin
        mc_s = sa_r;
        mp   = COEF_FB_A;
        sub  = 1'b1;
      end
      OP_FBB: begin
        mc_s = sb_r;
        mp   = COEF_FB_B;
        sub  = 1'b1;
      end
      OP_AA: begin
        mc_s = sa_r;
        mp   = COEF_AA;
      end
      OP_AB: begin
        mc_s = sb_r;
        mp   = COEF_AB;
      end
      OP_AD: begin
        mc_s = d_r;
        mp   = COEF_AD;
      end
      OP_BA: begin
        mc_s = sa_r;
        mp   = COEF_BA;
      end
      OP_BB: begin
        mc_s = sb_r;
        mp   = COEF_BB;
      end
      OP_BD: begin
        mc_s = d_r;
        mp   = COEF_BD;
      end
      default: begin
        mc_s = STATE_WIDTH'(e_r);
        mp   = COEF_AA;
      end
    endcase
    mc_mag = mc_s[STATE_WIDTH-1] ? (~mc_s + 1'b1) : mc_s;
  end

  assign mul_start = (state_r == S_MSTART);

  pcdq_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mc_mag),
    .mplier (mp),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  // Round the product magnitude to nearest, half away from zero
  always_comb begin
    r_pre  = {1'b0, mul_prod};
    r_half = HALF_COEF;
    case (rsel)
      RND_SP: begin
        r_pre  = {1'b0, mul_prod} << SP_LSH;
        r_half = HALF_SP;
      end
      RND_PG:   r_half = HALF_PG;
      RND_IG:   r_half = HALF_IG;
      RND_COEF: r_half = HALF_COEF;
      default:  r_half = HALF_COEF;
    endcase
    r_sum = r_pre + r_half;
    case (rsel)
      RND_SP:   r_shf = r_sum >> SP_RSH;
      RND_PG:   r_shf = r_sum >> PG_RSH;
      RND_IG:   r_shf = r_sum >> IG_RSH;
      RND_COEF: r_shf = r_sum >> COEF_RSH;
      default:  r_shf = r_sum >> COEF_RSH;
    endcase
  end

  // Signed term: negative multiplicand or feedback subtract flips it
  assign flip     = mc_s[STATE_WIDTH-1] ^ sub;
  assign add_term = flip ? ~$signed({1'b0, rmag_r}) : $signed({1'b0, rmag_r});

  assign u_sat    = sat_q(acc_r);
  assign v_pos    = $signed({1'b0, cfg.output_level});
  assign v_sel    = (acc_r > 0) ? v_pos : -v_pos;
  assign v_m_u    = 17'(v_sel) - 17'(u_r);
  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    integ_nxt     = integ_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    na_nxt        = na_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    rmag_nxt      = rmag_r;
    e_nxt         = e_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    pos_nxt       = pos_r;
    drv_pos_nxt   = drv_pos_r;
    drv_val_nxt   = drv_val_r;
    cmd_nxt       = cmd_r;

    // Drop the result once transferred
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          e_nxt     = in_ch.error_in;
          acc_nxt   = '0;
          op_nxt    = OP_SP;
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        rmag_nxt  = r_shf[RMAG_W-1:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r + add_term + ACC_W'(flip);
        case (op_r)
          OP_SP:   state_nxt = S_INTEG;
          OP_IG:   state_nxt = S_UCMD;
          OP_FBB:  state_nxt = S_SIGN;
          OP_AD:   state_nxt = S_STA;
          OP_BD:   state_nxt = S_STB;
          default: begin
            op_nxt    = op_t'(op_r + 4'd1);
            state_nxt = S_MSTART;
          end
        endcase
      end
      // Integrator takes the rounded error times sample period
      S_INTEG: begin
        integ_nxt = sat_sw(acc_r + ACC_W'(integ_r));
        acc_nxt   = '0;
        op_nxt    = OP_PG;
        state_nxt = S_MSTART;
      end
      // Saturate the command, start the shaper sum from it
      S_UCMD: begin
        u_nxt     = u_sat;
        acc_nxt   = ACC_W'(u_sat) <<< US_LSH;
        op_nxt    = OP_FBA;
        state_nxt = S_MSTART;
      end
      // Pick the drive level from the sign, form the quantization error
      S_SIGN: begin
        pos_nxt   = (acc_r > 0);
        v_nxt     = v_sel;
        d_nxt     = STATE_WIDTH'(v_m_u) <<< US_LSH;
        acc_nxt   = '0;
        op_nxt    = OP_AA;
        state_nxt = S_MSTART;
      end
      S_STA: begin
        na_nxt    = sat_sw(acc_r);
        acc_nxt   = '0;
        op_nxt    = OP_BA;
        state_nxt = S_MSTART;
      end
      // Commit both shaper states together with the result
      S_STB: begin
        if (out_free) begin
          sb_nxt        = sat_sw(acc_r);
          sa_nxt        = na_r;
          drv_pos_nxt   = pos_r;
          drv_val_nxt   = v_r;
          cmd_nxt       = u_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, loop state, working values and result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_SP;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      sa_r        <= '0;
      sb_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      sa_r        <= sa_nxt;
      sb_r        <= sb_nxt;
      na_r        <= na_nxt;
      d_r         <= d_nxt;
      acc_r       <= acc_nxt;
      rmag_r      <= rmag_nxt;
      e_r         <= e_nxt;
      u_r         <= u_nxt;
      v_r         <= v_nxt;
      pos_r       <= pos_nxt;
      drv_pos_r   <= drv_pos_nxt;
      drv_val_r   <= drv_val_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive_positive = drv_pos_r;
  assign out_ch.drive_value    = drv_val_r;
  assign out_ch.command_value  = cmd_r;

endmodule

`default_nettype wire

// ===== dv/pcdq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcdq_checker: drive predictor and result comparator
// Watches the error sample channel, the drive result channel and the register
// write port. Each error transfer runs through a bit-exact model of the PI
// stage and the second-order shaper, and the predicted drive is queued. Each
// result transfer is compared field by field with the oldest queued drive.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdq_checker import pcdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pcdq_in_if                    in_ch,
  pcdq_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  // Fixed-point layout of the model state
  localparam int     ACC_FRAC   = STATE_WIDTH - 16;
  localparam int     SHAPE_FRAC = STATE_WIDTH - 8;
  localparam int     K_FRAC     = 24;
  localparam longint MAG_CAP    = longint'(1) <<< 60;

  // Shaper feedback and update coefficients, 24 fraction bits
  localparam longint K_FB_A = 1388019345;
  localparam longint K_FB_B = 52823232;
  localparam longint K_AA   = 15969343;
  localparam longint K_AB   = 607738;
  localparam longint K_AD   = 193024;
  localparam longint K_BA   = 693580;
  localparam longint K_BB   = 9786452;
  localparam longint K_BD   = 6337536;

  typedef struct packed {
    logic               drive_positive;
    logic signed [15:0] drive_value;
    logic signed [15:0] command_value;
  } drive_t;

  cfg_t   regs;
  longint integ_acc;
  longint shape_a;
  longint shape_b;
  drive_t expected_drives[$];

  // Clamp to a signed field of w bits
  function automatic longint clamp_signed(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Round half away from zero on a right shift, plain left shift otherwise
  function automatic longint round_scale(longint x, int sh);
    bit          neg;
    logic [63:0] m;
    neg = x < 0;
    m   = neg ? 64'(-x) : 64'(x);
    if (sh > 0) begin
      m = (m + (64'd1 << (sh - 1))) >> sh;
    end else if (sh < 0) begin
      m = m << (-sh);
    end
    if (m > 64'(MAG_CAP)) m = 64'(MAG_CAP);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // Full-width product, rounded on the right shift and capped in magnitude
  function automatic longint mul_round(longint a, longint b, int sh);
    bit           neg;
    logic [63:0]  ma;
    logic [31:0]  mb;
    logic [127:0] prod;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? 64'(-a) : 64'(a);
    mb   = 32'((b < 0) ? -b : b);
    prod = 128'(ma) * 128'(mb);
    prod = (prod + (128'd1 << (sh - 1))) >> sh;
    if (prod > 128'(MAG_CAP)) prod = 128'(MAG_CAP);
    return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  // Advance the controller by one error sample and return its drive
  function automatic drive_t step_controller(logic signed [15:0] err);
    longint e;
    longint inc;
    longint pterm;
    longint iterm;
    longint u;
    longint sig;
    longint v;
    longint d;
    longint na;
    longint nb;
    drive_t r;
    e = err;

    // PI stage
    inc       = round_scale(e * longint'(regs.sample_period), 28 - ACC_FRAC);
    integ_acc = clamp_signed(integ_acc + inc, STATE_WIDTH);
    pterm     = round_scale(e * longint'(regs.prop_gain), 16);
    iterm     = mul_round(integ_acc, longint'(regs.integ_gain), ACC_FRAC + 4);
    u         = clamp_signed(pterm + iterm, 16);

    // Sign decision on the command minus the shaper feedback
    sig = round_scale(u, 12 - SHAPE_FRAC)
        - (mul_round(shape_a, K_FB_A, K_FRAC) + mul_round(shape_b, K_FB_B, K_FRAC));
    v   = (sig > 0) ? longint'(regs.output_level) : -longint'(regs.output_level);
    d   = round_scale(v - u, 12 - SHAPE_FRAC);

    // Both new states come from the old pair
    na = mul_round(shape_a, K_AA, K_FRAC) + mul_round(shape_b, K_AB, K_FRAC)
       + mul_round(d, K_AD, K_FRAC);
    nb = mul_round(shape_a, K_BA, K_FRAC) + mul_round(shape_b, K_BB, K_FRAC)
       + mul_round(d, K_BD, K_FRAC);
    shape_a = clamp_signed(na, STATE_WIDTH);
    shape_b = clamp_signed(nb, STATE_WIDTH);

    r.drive_positive = sig > 0;
    r.drive_value    = v[15:0];
    r.command_value  = u[15:0];
    return r;
  endfunction

  // Count a failure, report the first few
  function automatic void check_field(string field, logic signed [15:0] want,
                                      logic signed [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR %0t: %0s expected %0d got %0d", $realtime, field, want, got);
      end
    end
  endfunction

  // Track registers, predict on error transfers, compare on drive transfers
  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      regs.prop_gain     = PROP_GAIN_RST;
      regs.integ_gain    = INTEG_GAIN_RST;
      regs.sample_period = SAMPLE_PERIOD_RST;
      regs.output_level  = OUTPUT_LEVEL_RST;
      integ_acc          = 0;
      shape_a            = 0;
      shape_b            = 0;
      fail_count         = 0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          REG_PROP_GAIN:     regs.prop_gain     = cfg_wdata;
          REG_INTEG_GAIN:    regs.integ_gain    = cfg_wdata;
          REG_SAMPLE_PERIOD: regs.sample_period = cfg_wdata[15:0];
          REG_OUTPUT_LEVEL:  regs.output_level  = cfg_wdata[14:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        expected_drives.push_back(step_controller(in_ch.error_in));
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR %0t: drive transfer with no sample outstanding", $realtime);
          end
        end else begin
          want = expected_drives.pop_front();
          check_field("drive_positive", 16'(want.drive_positive),
                      16'(out_ch.drive_positive));
          check_field("drive_value", want.drive_value, out_ch.drive_value);
          check_field("command_value", want.command_value, out_ch.command_value);
        end
      end
    end
    pending = expected_drives.size();
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression of the PI controller with dynamic quantizer
// Drives error samples and register writes into the block under random
// idling and back-pressure, with two long output hold-offs, and leaves the
// prediction and comparison to the checker instantiated beside it.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import pcdq_pkg::*;

  localparam int ITEM_CYCLES  = 93;
  localparam int HOLD_CYCLES  = 500;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 241;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    hold_request;

  pcdq_in_if  sample_ch ();
  pcdq_out_if drive_ch ();

  pi_control_dynamic_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_ch),
    .out_ch    (drive_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pcdq_checker pi_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (sample_ch),
    .out_ch     (drive_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #25_000_000;
    $display("pi_control_dynamic_quantizer regression: fail");
    $finish;
  end

  // Sender idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 20);
    return $urandom_range(60, 250);
  endfunction

  // Error sample mix: full range, small, extremes, mid scale
  function automatic logic signed [15:0] pick_error();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom);
    if (r < 70) return 16'($urandom_range(0, 1024) - 512);
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0:       return 16'sd32767;
        1:       return -16'sd32768;
        2:       return 16'sd0;
        3:       return 16'sd1;
        default: return -16'sd1;
      endcase
    end
    return 16'($urandom_range(0, 8191) - 4096);
  endfunction

  // Register value: zero, full scale, default, near default or anything
  function automatic logic [23:0] pick_reg(int width, logic [23:0] dflt);
    logic [23:0] mask;
    mask = (24'd1 << width) - 24'd1;
    case ($urandom_range(0, 9))
      0:             return 24'd0;
      1:             return mask;
      2:             return dflt;
      3, 4, 5, 6:    return 24'($urandom_range(0, 2 * dflt));
      default:       return 24'($urandom) & mask;
    endcase
  endfunction

  // Offer one error sample, hold it until transfer, then idle a while
  task automatic offer_error(logic signed [15:0] err);
    int gap;
    @(negedge clk);
    sample_ch.valid    <= 1'b1;
    sample_ch.error_in <= err;
    do @(posedge clk); while (!sample_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding drive to come back
  task automatic quiesce();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (ITEM_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(logic [23:0] pg, logic [23:0] ig, logic [23:0] sp,
                           logic [23:0] ol);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INTEG_GAIN, ig);
    write_reg(REG_SAMPLE_PERIOD, sp);
    write_reg(REG_OUTPUT_LEVEL, ol);
  endtask

  // Result side: random ready with long hold-offs on request
  initial begin
    int r;
    int len;
    int holds_done;
    holds_done     = 0;
    drive_ch.ready = 1'b0;
    forever begin
      if (hold_request != holds_done) begin
        holds_done++;
        @(negedge clk);
        drive_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) len = $urandom_range(1, 40);
        else if (r < 92) len = $urandom_range(1, 3);
        else len = $urandom_range(20, 150);
        @(negedge clk);
        drive_ch.ready <= (r < 65);
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic signed [15:0] corner_errors[14];
    corner_errors = '{16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
                      16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                      16'sd16384, -16'sd16384, 16'sh5555, 16'shAAAA};
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    sample_ch.valid    = 1'b0;
    sample_ch.error_in = '0;
    hold_request       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: the first zero sample meets a zero shaper sum
    foreach (corner_errors[i]) offer_error(corner_errors[i]);
    quiesce();

    // Zero output level
    write_reg(REG_OUTPUT_LEVEL, 24'd0);
    offer_error(16'sd0);
    offer_error(16'sd1);
    offer_error(-16'sd1);
    offer_error(16'sd32767);
    offer_error(-16'sd32768);
    quiesce();

    // Everything at full scale, command saturates
    write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFF, 24'h7FFF);
    offer_error(16'sd32767);
    offer_error(-16'sd32768);
    offer_error(16'sd32767);
    offer_error(16'sd100);
    quiesce();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_all(PROP_GAIN_RST, INTEG_GAIN_RST, 24'(SAMPLE_PERIOD_RST),
                     24'(OUTPUT_LEVEL_RST));
        1: write_all(24'd0, 24'd0, 24'd0, 24'd0);
        2: write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFF, 24'h7FFF);
        default: write_all(pick_reg(24, PROP_GAIN_RST), pick_reg(24, INTEG_GAIN_RST),
                           pick_reg(16, 24'(SAMPLE_PERIOD_RST)),
                           pick_reg(15, 24'(OUTPUT_LEVEL_RST)));
      endcase
      if (ph == 3 || ph == 6) hold_request++;
      repeat (PHASE_ITEMS) offer_error(pick_error());
      quiesce();
    end

    repeat (2 * ITEM_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("pi_control_dynamic_quantizer regression: pass");
    end else begin
      $display("pi_control_dynamic_quantizer regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
